/* rtl/core/fpn_pkg.sv */
// shared types and constants for the fixed-pattern noise correction block
package fpn_pkg;

    localparam int PIX_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int COORD_W = 14;
    localparam int DIM_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // divider: quotient bits, dividend is the pixel difference shifted by the gain point
    localparam int GAIN_FRAC = 14;
    localparam int QUO_W     = PIX_W;
    localparam int NUM_W     = 17 + GAIN_FRAC;
    localparam int PROD_W    = PIX_W + GAIN_W;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_VALID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic OP_CORRECT = 1'b0;
    localparam logic OP_RESTORE = 1'b1;

    typedef enum logic [1:0] {
        K_VALUE   = 2'd0,  // result already final in aux
        K_DIV     = 2'd1,  // quotient built by the cell chain
        K_RESTORE = 2'd2   // product in aux, dark added at the end
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [NUM_W-1:0]         num;
        logic [GAIN_W-1:0]        den;
        logic [QUO_W-1:0]         quo;
        logic [PROD_W-1:0]        aux;
        logic signed [PIX_W-1:0]  dark;
    } t_lane;

endpackage

/* rtl/core/fpn_front.sv */
// entry stage: bounds check, dark step, restore multiply, divider setup
module fpn_front #(
    parameter int MAX_DIM = 16384
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic                              i_model_valid,
    input  logic                              i_dark_enable,
    input  logic                              i_gain_enable,
    input  logic [fpn_pkg::DIM_W-1:0]         i_frame_width,
    input  logic [fpn_pkg::DIM_W-1:0]         i_frame_height,
    input  logic                              i_operation,
    input  logic [fpn_pkg::PIX_W-1:0]         i_pixel_in,
    input  logic [fpn_pkg::COORD_W-1:0]       i_row,
    input  logic [fpn_pkg::COORD_W-1:0]       i_col,
    input  logic signed [fpn_pkg::PIX_W-1:0]  i_dark_offset,
    input  logic [fpn_pkg::GAIN_W-1:0]        i_gain_code,
    output logic                              o_valid,
    output fpn_pkg::t_lane                    o_lane
);

    localparam logic [16:0] DIM_LIM = 17'(MAX_DIM);

    logic                  r_valid;
    fpn_pkg::t_lane        r_lane;
    fpn_pkg::t_lane        n_lane;
    logic                  w_inside;
    logic                  w_dark_use;
    logic                  w_gain_use;
    logic signed [17:0]    w_diff;
    logic [fpn_pkg::PROD_W-1:0] w_prod;

    always_comb begin
        w_inside = (17'(i_row) < 17'(i_frame_height)) && (17'(i_row) < DIM_LIM) &&
                   (17'(i_col) < 17'(i_frame_width))  && (17'(i_col) < DIM_LIM);
        w_dark_use = i_dark_enable & w_inside;
        w_gain_use = i_gain_enable & w_inside;
        w_diff = $signed({2'b00, i_pixel_in}) -
                 (w_dark_use ? 18'(i_dark_offset) : 18'sd0);
        w_prod = w_gain_use ? (fpn_pkg::PROD_W'(i_pixel_in) * fpn_pkg::PROD_W'(i_gain_code))
                            : fpn_pkg::PROD_W'({i_pixel_in, 14'd0});
    end

    always_comb begin
        n_lane      = '0;
        n_lane.kind = fpn_pkg::K_VALUE;
        if (!i_model_valid) begin
            n_lane.aux = fpn_pkg::PROD_W'(i_pixel_in);
        end else if (i_operation == fpn_pkg::OP_RESTORE) begin
            n_lane.kind = fpn_pkg::K_RESTORE;
            n_lane.aux  = w_prod;
            n_lane.dark = w_dark_use ? i_dark_offset : '0;
        end else if (w_gain_use && (i_gain_code != '0)) begin
            if (w_diff <= 18'sd0) begin
                n_lane.aux = '0;
            end else if (19'(w_diff) >= $signed({1'b0, i_gain_code, 2'b00})) begin
                // quotient would not fit in 16 bits
                n_lane.aux = fpn_pkg::PROD_W'(fpn_pkg::PIX_MAX);
            end else begin
                n_lane.kind = fpn_pkg::K_DIV;
                n_lane.num  = {w_diff[16:0], 14'd0};
                n_lane.den  = i_gain_code;
            end
        end else begin
            if (w_diff < 18'sd0) begin
                n_lane.aux = '0;
            end else if (w_diff > 18'sd65535) begin
                n_lane.aux = fpn_pkg::PROD_W'(fpn_pkg::PIX_MAX);
            end else begin
                n_lane.aux = fpn_pkg::PROD_W'(w_diff[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* rtl/core/fpn_cell.sv */
// one restoring-division cell: settles one quotient bit and passes the lane on
module fpn_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  fpn_pkg::t_lane  i_lane,
    output logic            o_valid,
    output fpn_pkg::t_lane  o_lane
);

    logic                       r_valid;
    fpn_pkg::t_lane             r_lane;
    fpn_pkg::t_lane             n_lane;
    logic [fpn_pkg::NUM_W:0]    w_den_sh;

    always_comb begin
        n_lane   = i_lane;
        w_den_sh = (fpn_pkg::NUM_W + 1)'(i_lane.den) << SHIFT;
        if ((i_lane.kind == fpn_pkg::K_DIV) &&
            ({1'b0, i_lane.num} >= w_den_sh)) begin
            n_lane.num        = i_lane.num - w_den_sh[fpn_pkg::NUM_W-1:0];
            n_lane.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* rtl/core/fpn_back.sv */
// exit stage: restore add, result select, saturation and output register
module fpn_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  fpn_pkg::t_lane             i_lane,
    output logic                       o_valid,
    output logic [fpn_pkg::PIX_W-1:0]  o_pixel_out
);

    logic                       r_valid;
    logic [fpn_pkg::PIX_W-1:0]  r_pixel;
    logic [fpn_pkg::PIX_W-1:0]  n_pixel;
    logic signed [19:0]         w_sum;

    always_comb begin
        w_sum = $signed({2'b00, i_lane.aux[fpn_pkg::PROD_W-1:fpn_pkg::GAIN_FRAC]}) +
                20'(i_lane.dark);
        case (i_lane.kind)
            fpn_pkg::K_DIV: begin
                n_pixel = i_lane.quo;
            end
            fpn_pkg::K_RESTORE: begin
                if (w_sum < 20'sd0) begin
                    n_pixel = '0;
                end else if (w_sum > 20'sd65535) begin
                    n_pixel = fpn_pkg::PIX_MAX;
                end else begin
                    n_pixel = w_sum[15:0];
                end
            end
            default: begin
                n_pixel = i_lane.aux[fpn_pkg::PIX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid     = r_valid;
    assign o_pixel_out = r_pixel;

endmodule

/* rtl/core/fixed_pattern_noise_correction.sv */
// top level of the per-pixel dark offset and gain correction block
//
// Input channel i_valid / o_stall carries one pixel per beat with its
// coordinates, signed dark offset and 2.14 gain. Output channel o_valid /
// i_stall carries the corrected (operation 0) or restored (operation 1) pixel,
// saturated to 16 bits, one result per input beat, in order.
// Registers are written through i_cfg_valid / o_cfg_ready (always ready) at
// index i_cfg_index; write them only while no pixel is in flight.
// The path is an entry stage (bounds, dark subtract, 16x16 multiply),
// a row of 16 division cells that each settle one quotient bit, and the
// output register. Every pixel walks the whole row, so the block takes one
// pixel per cycle in both modes while the row is not held by a stall.
// When the receiver stalls with a result waiting, the whole row holds and
// o_stall rises; a free output register lets the row keep moving.
// Synchronous active-low reset empties the row, clears the valid flags and the
// config registers, so pixels pass through unchanged until model_valid is set.
module fixed_pattern_noise_correction #(
    parameter int MAX_DIM = 16384
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fpn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fpn_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_operation,
    input  logic [fpn_pkg::PIX_W-1:0]             i_pixel_in,
    input  logic [fpn_pkg::COORD_W-1:0]           i_row,
    input  logic [fpn_pkg::COORD_W-1:0]           i_col,
    input  logic signed [fpn_pkg::PIX_W-1:0]      i_dark_offset,
    input  logic [fpn_pkg::GAIN_W-1:0]            i_gain_code,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [fpn_pkg::PIX_W-1:0]             o_pixel_out
);

    localparam int N_CELLS = fpn_pkg::QUO_W;

    logic                        r_model_valid;
    logic                        r_dark_enable;
    logic                        r_gain_enable;
    logic [fpn_pkg::DIM_W-1:0]   r_frame_width;
    logic [fpn_pkg::DIM_W-1:0]   r_frame_height;

    logic                        w_adv;
    logic                        w_out_valid;
    logic                        w_valid [N_CELLS+1];
    fpn_pkg::t_lane              w_lane  [N_CELLS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_valid  <= 1'b0;
            r_dark_enable  <= 1'b0;
            r_gain_enable  <= 1'b0;
            r_frame_width  <= '0;
            r_frame_height <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpn_pkg::REG_MODEL_VALID:  r_model_valid  <= i_cfg_data[0];
                fpn_pkg::REG_DARK_ENABLE:  r_dark_enable  <= i_cfg_data[0];
                fpn_pkg::REG_GAIN_ENABLE:  r_gain_enable  <= i_cfg_data[0];
                fpn_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                fpn_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // the row moves whenever the output register is empty or being taken
    assign w_adv   = !w_out_valid || !i_stall;
    assign o_stall = !w_adv;

    fpn_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_adv),
        .i_valid        (i_valid),
        .i_model_valid  (r_model_valid),
        .i_dark_enable  (r_dark_enable),
        .i_gain_enable  (r_gain_enable),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_operation    (i_operation),
        .i_pixel_in     (i_pixel_in),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_dark_offset  (i_dark_offset),
        .i_gain_code    (i_gain_code),
        .o_valid        (w_valid[0]),
        .o_lane         (w_lane[0])
    );

    // cell k settles quotient bit N_CELLS-1-k
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        fpn_cell #(
            .SHIFT (N_CELLS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[k]),
            .i_lane  (w_lane[k]),
            .o_valid (w_valid[k+1]),
            .o_lane  (w_lane[k+1])
        );
    end

    fpn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (w_valid[N_CELLS]),
        .i_lane      (w_lane[N_CELLS]),
        .o_valid     (w_out_valid),
        .o_pixel_out (o_pixel_out)
    );

    assign o_valid = w_out_valid;

endmodule

/* tb/fpn_pixel_checker.sv */
// checker for the fpn correction block: tracks the registers, predicts each pixel, compares
`timescale 1ns / 100ps

module fpn_pixel_checker
    import fpn_pkg::*;
#(
    parameter int MAX_DIM = 16384
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_operation,
    input  logic [PIX_W-1:0]           i_pixel_in,
    input  logic [COORD_W-1:0]         i_row,
    input  logic [COORD_W-1:0]         i_col,
    input  logic signed [PIX_W-1:0]    i_dark_offset,
    input  logic [GAIN_W-1:0]          i_gain_code,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [PIX_W-1:0]           i_pixel_out,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint GAIN_ONE = 64'sd16384;

    logic             model_valid;
    logic             dark_en;
    logic             gain_en;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;

    logic [PIX_W-1:0] expected_pixels[$];
    int               mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [PIX_W-1:0] corrected_pixel(
        input logic                    op,
        input logic [PIX_W-1:0]        pix,
        input logic [COORD_W-1:0]      row,
        input logic [COORD_W-1:0]      col,
        input logic signed [PIX_W-1:0] dark,
        input logic [GAIN_W-1:0]       gain
    );
        longint acc;
        longint ofs;
        longint g;
        longint w_lim;
        longint h_lim;
        bit     in_frame;
        if (!model_valid) return pix;
        w_lim    = (frame_w > MAX_DIM) ? MAX_DIM : frame_w;
        h_lim    = (frame_h > MAX_DIM) ? MAX_DIM : frame_h;
        in_frame = (longint'(row) < h_lim) && (longint'(col) < w_lim);
        acc      = longint'(pix);
        ofs      = longint'(dark);
        g        = longint'(gain);
        if (op == OP_CORRECT) begin
            if (dark_en && in_frame) acc = acc - ofs;
            // zero gain leaves the dark-corrected value as it is
            if (gain_en && in_frame && g != 0) acc = (acc * GAIN_ONE) / g;
        end else begin
            if (gain_en && in_frame) acc = (acc * g) / GAIN_ONE;
            if (dark_en && in_frame) acc = acc + ofs;
        end
        if (acc < 0) return '0;
        if (acc > longint'(PIX_MAX)) return PIX_MAX;
        return acc[PIX_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [PIX_W-1:0] want;
        if (!i_rst_n) begin
            model_valid = 1'b0;
            dark_en     = 1'b0;
            gain_en     = 1'b0;
            frame_w     = '0;
            frame_h     = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODEL_VALID:  model_valid = i_cfg_data[0];
                    REG_DARK_ENABLE:  dark_en     = i_cfg_data[0];
                    REG_GAIN_ENABLE:  gain_en     = i_cfg_data[0];
                    REG_FRAME_WIDTH:  frame_w     = i_cfg_data;
                    REG_FRAME_HEIGHT: frame_h     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(corrected_pixel(i_operation, i_pixel_in, i_row,
                                                          i_col, i_dark_offset, i_gain_code));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: beat with no pixel in flight, actual %0d", i_pixel_out);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_out !== want) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d", want,
                               i_pixel_out);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
        o_errors  <= mismatches;
    end

endmodule

/* tb/tb_fixed_pattern_noise_correction.sv */
// testbench top for the fpn correction block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_fixed_pattern_noise_correction;
    import fpn_pkg::*;

    localparam int MAX_DIM        = 16384;
    localparam int LATENCY        = 18;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RAND_PHASES    = 14;
    localparam int PHASE_ITEMS    = 125;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_operation;
    logic [PIX_W-1:0]        i_pixel_in;
    logic [COORD_W-1:0]      i_row;
    logic [COORD_W-1:0]      i_col;
    logic signed [PIX_W-1:0] i_dark_offset;
    logic [GAIN_W-1:0]       i_gain_code;
    logic                    o_valid;
    logic                    i_stall;
    logic [PIX_W-1:0]        o_pixel_out;

    int errors;
    int pixels_in_flight;

    // idle control shared between the sender, the stall process and the phases
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;
    int frame_cols  = 0;
    int frame_rows  = 0;

    always #6 i_clk = ~i_clk;

    fixed_pattern_noise_correction #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_pixel_in   (i_pixel_in),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_dark_offset(i_dark_offset),
        .i_gain_code  (i_gain_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out)
    );

    fpn_pixel_checker #(
        .MAX_DIM(MAX_DIM)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_operation  (i_operation),
        .i_pixel_in   (i_pixel_in),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_dark_offset(i_dark_offset),
        .i_gain_code  (i_gain_code),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_pixel_out  (o_pixel_out),
        .o_errors     (errors),
        .o_pending    (pixels_in_flight)
    );

    // receiver back-pressure
    initial begin : rx_stall_gen
        int go_len;
        int stall_len;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_calm) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                go_len    = $urandom_range(1, 6);
                stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(15, 50);
                i_stall <= 1'b0;
                repeat (go_len) @(posedge i_clk);
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic int tx_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 16383;
            3:       return 16384;
            4:       return 16385;
            5:       return 32767;
            6, 7:    return $urandom_range(1, 200);
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim > 0 && r < 7) return COORD_W'($urandom_range(0, lim - 1));
        // first position past the frame edge
        if (r == 7 && lim > 0 && lim < MAX_DIM) return COORD_W'(lim);
        return COORD_W'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_model(input bit mv, input bit de, input bit ge, input int w, input int h);
        logic [CFG_DATA_W-1:0] junk;
        // flag registers only look at bit 0, so the upper bits get random junk at times
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_MODEL_VALID, {junk[CFG_DATA_W-1:1], mv});
        write_reg(REG_DARK_ENABLE, {junk[CFG_DATA_W-1:1], de});
        write_reg(REG_GAIN_ENABLE, {junk[CFG_DATA_W-1:1], ge});
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        frame_cols = (w > MAX_DIM) ? MAX_DIM : w;
        frame_rows = (h > MAX_DIM) ? MAX_DIM : h;
    endtask

    task automatic send_pixel(
        input logic                    op,
        input logic [PIX_W-1:0]        pix,
        input logic [COORD_W-1:0]      row,
        input logic [COORD_W-1:0]      col,
        input logic signed [PIX_W-1:0] dark,
        input logic [GAIN_W-1:0]       gain
    );
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_pixel_in    <= pix;
        i_row         <= row;
        i_col         <= col;
        i_dark_offset <= dark;
        i_gain_code   <= gain;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random_pixel();
        logic [PIX_W-1:0]        pix;
        logic signed [PIX_W-1:0] dark;
        logic [GAIN_W-1:0]       gain;
        case ($urandom_range(0, 7))
            0:       pix = '0;
            1:       pix = PIX_MAX;
            default: pix = PIX_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       dark = 16'sh8000;
            1:       dark = 16'sh7fff;
            2:       dark = PIX_W'($urandom_range(0, 600) - 300);
            default: dark = PIX_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       gain = '0;
            1:       gain = 16'd1;
            2:       gain = 16'd16384;
            3:       gain = 16'hffff;
            4, 5:    gain = GAIN_W'($urandom_range(12000, 24000));
            default: gain = GAIN_W'($urandom);
        endcase
        send_pixel(($urandom_range(0, 1) == 0) ? OP_CORRECT : OP_RESTORE, pix,
                   pick_coord(frame_rows), pick_coord(frame_cols), dark, gain);
    endtask

    // wait until every pixel sent so far has come out, then let the row settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_in_flight != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_MODEL_VALID;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_operation   <= OP_CORRECT;
        i_pixel_in    <= '0;
        i_row         <= '0;
        i_col         <= '0;
        i_dark_offset <= '0;
        i_gain_code   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still at reset: no model, pixels pass through
        send_pixel(OP_CORRECT, 16'hffff, 14'd0, 14'd0, 16'sh7fff, 16'd1);
        send_pixel(OP_RESTORE, 16'd1234, 14'h3fff, 14'h3fff, 16'sh8000, 16'hffff);
        repeat (3) send_random_pixel();
        drain();

        // oversized frame clamps to the maximum dimension
        set_model(1'b1, 1'b1, 1'b1, 32767, 32767);
        send_pixel(OP_CORRECT, 16'd0, 14'd0, 14'd0, 16'sh7fff, 16'd16384);
        send_pixel(OP_CORRECT, 16'hffff, 14'd5, 14'd7, 16'sh8000, 16'd16384);
        send_pixel(OP_CORRECT, 16'd1000, 14'd1, 14'd1, 16'sd100, 16'd0);
        send_pixel(OP_CORRECT, 16'd1000, 14'd2, 14'd3, 16'sd0, 16'd1);
        send_pixel(OP_CORRECT, 16'hffff, 14'd9, 14'd9, 16'sd0, 16'hffff);
        send_pixel(OP_CORRECT, 16'd30000, 14'd4, 14'd4, -16'sd5, 16'd8192);
        send_pixel(OP_RESTORE, 16'd1000, 14'd1, 14'd1, 16'sd50, 16'd0);
        send_pixel(OP_RESTORE, 16'hffff, 14'd1, 14'd1, 16'sh7fff, 16'hffff);
        send_pixel(OP_RESTORE, 16'd10, 14'd1, 14'd1, 16'sh8000, 16'd16384);
        send_pixel(OP_RESTORE, 16'd40000, 14'd8, 14'd2, 16'sd0, 16'd20000);
        send_pixel(OP_CORRECT, 16'd5000, 14'h3fff, 14'h3fff, 16'sd200, 16'd20000);
        drain();

        set_model(1'b1, 1'b1, 1'b1, 16384, 16384);
        send_pixel(OP_CORRECT, 16'd5000, 14'h3fff, 14'd0, 16'sd200, 16'd8192);
        drain();

        // small frame: coordinates on and past the edges
        set_model(1'b1, 1'b1, 1'b1, 100, 50);
        send_pixel(OP_CORRECT, 16'd7000, 14'd50, 14'd0, 16'sd300, 16'd8192);
        send_pixel(OP_CORRECT, 16'd7000, 14'd0, 14'd100, 16'sd300, 16'd8192);
        send_pixel(OP_CORRECT, 16'd7000, 14'd49, 14'd99, 16'sd300, 16'd8192);
        send_pixel(OP_RESTORE, 16'd7000, 14'd60, 14'd120, 16'sh8000, 16'd0);
        drain();

        set_model(1'b1, 1'b0, 1'b1, 200, 200);
        send_pixel(OP_CORRECT, 16'd3000, 14'd1, 14'd1, 16'sd900, 16'd12000);
        send_pixel(OP_RESTORE, 16'd3000, 14'd1, 14'd1, 16'sd900, 16'd12000);
        drain();
        set_model(1'b1, 1'b1, 1'b0, 200, 200);
        send_pixel(OP_CORRECT, 16'd3000, 14'd1, 14'd1, 16'sd900, 16'd12000);
        send_pixel(OP_RESTORE, 16'd3000, 14'd1, 14'd1, -16'sd900, 16'd12000);
        drain();
        set_model(1'b1, 1'b1, 1'b1, 0, 0);
        send_pixel(OP_CORRECT, 16'd3000, 14'd0, 14'd0, 16'sd900, 16'd12000);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 3) begin
                // long receiver hold while the sender keeps pushing
                set_model(1'b1, 1'b1, 1'b1, 16384, 16384);
                tx_calm     = 1'b1;
                rx_calm     = 1'b0;
                rx_hold_req = 1'b1;
            end else begin
                set_model($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_dim(), pick_dim());
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            repeat (PHASE_ITEMS) send_random_pixel();
            drain();
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (2 * LATENCY) @(posedge i_clk);
        if (errors == 0 && pixels_in_flight == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fpn_pkg.sv
rtl/core/fpn_front.sv
rtl/core/fpn_cell.sv
rtl/core/fpn_back.sv
rtl/core/fixed_pattern_noise_correction.sv
tb/fpn_pixel_checker.sv
tb/tb_fixed_pattern_noise_correction.sv
